>>> rtl/core/sampled_integral_1d_core_macros.svh
// Assertion macros used by the checker file of the sampled integral core.
`ifndef SAMPLED_INTEGRAL_1D_CORE_MACROS_SVH
`define SAMPLED_INTEGRAL_1D_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SINT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sampled_integral_1d_core: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SINT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sampled_integral_1d_core: check failed");

`endif

>>> rtl/core/sint_pkg.sv
// Types, constants and helper functions of the sampled integral core.
package sint_pkg;

    localparam int MAX_INTERVALS = 4096;
    localparam int SAMPLE_W      = 32;
    localparam int COUNT_W       = 13;
    localparam int POS_W         = $clog2(MAX_INTERVALS + 1);
    localparam int WEIGHT_W      = 4;
    localparam int SUM_W         = 48;
    localparam int BOUND_W       = 32;
    localparam int DIFF_W        = BOUND_W + 1;
    localparam int PROD_W        = DIFF_W + SUM_W;
    localparam int DIVISOR_W     = $clog2(6 * MAX_INTERVALS + 1);
    localparam int RESULT_W      = 64;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_MODE      = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_COUNT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_BOUND    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_BOUND    = CFG_INDEX_W'(3);

    localparam logic MODE_TRAPEZOID = 1'b0;
    localparam logic MODE_SIMPSON   = 1'b1;

    localparam logic [WEIGHT_W-1:0] W_TRAP_END   = WEIGHT_W'(3);
    localparam logic [WEIGHT_W-1:0] W_TRAP_INNER = WEIGHT_W'(6);
    localparam logic [WEIGHT_W-1:0] W_SIMP_END   = WEIGHT_W'(2);
    localparam logic [WEIGHT_W-1:0] W_SIMP_ODD   = WEIGHT_W'(8);
    localparam logic [WEIGHT_W-1:0] W_SIMP_EVEN  = WEIGHT_W'(4);
    localparam logic [WEIGHT_W-1:0] W_TAIL       = WEIGHT_W'(3);

    localparam logic [RESULT_W-1:0] RESULT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] RESULT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    typedef struct packed {
        logic                       rule_mode;
        logic [COUNT_W-1:0]         interval_count;
        logic [BOUND_W-1:0]         lower_bound;
        logic [BOUND_W-1:0]         upper_bound;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } t_entry;

    // Interval count as used: zero counts as one, large values clamp to the maximum.
    function automatic logic [POS_W-1:0] eff_n(input logic [COUNT_W-1:0] count);
        logic [POS_W-1:0] n;
        if (count == '0) begin
            n = POS_W'(1);
        end else if (32'(count) > MAX_INTERVALS) begin
            n = POS_W'(MAX_INTERVALS);
        end else begin
            n = POS_W'(count);
        end
        return n;
    endfunction

endpackage

>>> rtl/core/sampled_integral_1d_core.sv
// Top level of the sampled 1D integrator: configuration registers, front end, queue, back end.
//
// This core integrates a run of N+1 equally spaced signed Q16.16 samples over
// [lower_bound, upper_bound] by the trapezoidal rule (weights 3,6,...,6,3) or by
// Simpson's rule (2,8,4,...,8,2, with a trapezoid on the last interval when N is
// odd), and delivers (upper - lower) * sum / (6N) as a signed Q32.32 beat,
// saturated, with an overflow flag; it then starts the next run. Samples are
// taken at one beat per cycle: the front end assigns each sample its weight
// on arrival and pushes it into a four-entry queue, and the back end adds one
// weighted sample per cycle into a 48-bit accumulator. The last sample of a
// run hands the sum to the scaling unit: two 33x24 partial products, one
// final add, and a restoring divide by 6N that retires one quotient bit per
// cycle over 81 bits; the result beat then enters the output register as soon
// as that register is free. While that unit works the back end does not drain
// the queue, so the input stalls once four more samples have arrived. The
// finished result sits in an output register, which lets the next run proceed
// while it waits to be taken. Configuration registers (index 0 rule mode, 1
// interval count, 2 lower bound, 3 upper bound; other indexes are ignored) are
// always ready and are to be written only while no run result is outstanding.
// An interval count of zero acts as one, and counts above 4096 are clamped to
// 4096.
module sampled_integral_1d_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sint_pkg::SAMPLE_W-1:0]    i_sample_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sint_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sint_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sint_pkg::RESULT_W-1:0]    o_integral_value,
    output logic                             o_overflow_flag
);

    sint_pkg::t_cfg   r_cfg, n_cfg;
    sint_pkg::t_entry push_entry;
    sint_pkg::t_entry pop_entry;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_not_empty;
    logic             cfg_write;

    // The configuration port never back-pressures.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_write) begin
            case (i_cfg_index)
                sint_pkg::CFG_RULE_MODE: begin
                    n_cfg.rule_mode = i_cfg_data[0];
                end
                sint_pkg::CFG_INTERVAL_COUNT: begin
                    n_cfg.interval_count = i_cfg_data[sint_pkg::COUNT_W-1:0];
                end
                sint_pkg::CFG_LOWER_BOUND: begin
                    n_cfg.lower_bound = i_cfg_data[sint_pkg::BOUND_W-1:0];
                end
                sint_pkg::CFG_UPPER_BOUND: begin
                    n_cfg.upper_bound = i_cfg_data[sint_pkg::BOUND_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule_mode      <= sint_pkg::MODE_TRAPEZOID;
            r_cfg.interval_count <= sint_pkg::COUNT_W'(1);
            r_cfg.lower_bound    <= '0;
            r_cfg.upper_bound    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sint_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .i_sample (i_sample_value),
        .i_full   (q_full),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    sint_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_entry     (pop_entry)
    );

    sint_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_not_empty (q_not_empty),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_integral  (o_integral_value),
        .o_overflow  (o_overflow_flag)
    );

endmodule

>>> rtl/core/sint_front.sv
// Front end: accepts samples, tracks the grid position and assigns each sample its weight.
module sint_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sint_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  logic [sint_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_full,
    output logic                          o_stall,
    output logic                          o_push,
    output sint_pkg::t_entry              o_entry
);

    logic [sint_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [sint_pkg::POS_W-1:0]    eff;
    logic [sint_pkg::POS_W-1:0]    p;
    logic [sint_pkg::POS_W-1:0]    m;
    logic                          last;
    logic                          accept;
    logic [sint_pkg::WEIGHT_W-1:0] weight;

    assign eff    = sint_pkg::eff_n(i_cfg.interval_count);
    assign last   = r_pos >= eff;
    assign p      = last ? eff : r_pos;
    assign m      = {eff[sint_pkg::POS_W-1:1], 1'b0};
    assign accept = i_valid && !i_full;

    always_comb begin
        weight = '0;
        case (i_cfg.rule_mode)
            sint_pkg::MODE_TRAPEZOID: begin
                weight = (p == '0 || p == eff) ? sint_pkg::W_TRAP_END : sint_pkg::W_TRAP_INNER;
            end
            sint_pkg::MODE_SIMPSON: begin
                if (m != '0 && p <= m) begin
                    if (p == '0 || p == m) begin
                        weight = sint_pkg::W_SIMP_END;
                    end else if (p[0]) begin
                        weight = sint_pkg::W_SIMP_ODD;
                    end else begin
                        weight = sint_pkg::W_SIMP_EVEN;
                    end
                end
                // Odd interval count: the last interval is closed with a trapezoid.
                if (eff[0] && (p == (eff - sint_pkg::POS_W'(1)) || p == eff)) begin
                    weight = weight + sint_pkg::W_TAIL;
                end
            end
            default: begin
                weight = '0;
            end
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = last ? '0 : r_pos + sint_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_stall        = i_full;
    assign o_push         = accept;
    assign o_entry.sample = i_sample;
    assign o_entry.weight = weight;
    assign o_entry.last   = last;

endmodule

>>> rtl/core/sint_fifo.sv
// Short queue of classified samples between the front end and the back end.
module sint_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sint_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_not_empty,
    output sint_pkg::t_entry o_entry
);

    localparam int PTR_W = $clog2(sint_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(sint_pkg::FIFO_DEPTH + 1);

    sint_pkg::t_entry r_mem [sint_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full      = r_count == CNT_W'(sint_pkg::FIFO_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_entry     = r_mem[r_rd_ptr];

endmodule

>>> rtl/core/sint_back.sv
// Back end: weighted accumulation, final scaling by multiply and serial divide, output register.
module sint_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sint_pkg::t_cfg                i_cfg,
    input  logic                          i_not_empty,
    input  sint_pkg::t_entry              i_entry,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [sint_pkg::RESULT_W-1:0] o_integral,
    output logic                          o_overflow
);

    localparam int CONTRIB_W = sint_pkg::SAMPLE_W + sint_pkg::WEIGHT_W + 1;
    localparam int LO_W      = sint_pkg::SUM_W / 2;
    localparam int HI_W      = sint_pkg::SUM_W - LO_W;
    localparam int CNT_W     = $clog2(sint_pkg::PROD_W);
    localparam int QHI_W     = sint_pkg::PROD_W - sint_pkg::RESULT_W;

    typedef enum logic [6:0] {
        ST_ACCUM  = 7'b0000001,
        ST_SIGN   = 7'b0000010,
        ST_MUL_LO = 7'b0000100,
        ST_MUL_HI = 7'b0001000,
        ST_SUM    = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state                             r_state, n_state;
    logic signed [sint_pkg::SUM_W-1:0]  r_sum;
    logic signed [sint_pkg::SUM_W-1:0]  r_total;
    logic [sint_pkg::SUM_W-1:0]         r_smag;
    logic [sint_pkg::DIFF_W-1:0]        r_dmag;
    logic                               r_neg;
    logic [sint_pkg::DIVISOR_W-1:0]     r_div;
    logic [sint_pkg::DIFF_W+LO_W-1:0]   r_plo;
    logic [sint_pkg::DIFF_W+HI_W-1:0]   r_phi;
    logic [sint_pkg::PROD_W-1:0]        r_quot;
    logic [sint_pkg::DIVISOR_W-1:0]     r_rem;
    logic [CNT_W-1:0]                   r_cnt;
    logic                               r_out_vld, n_out_vld;
    logic [sint_pkg::RESULT_W-1:0]      r_out_value;
    logic                               r_out_ovf;

    logic signed [CONTRIB_W-1:0]        contrib;
    logic signed [sint_pkg::SUM_W-1:0]  sum_next;
    logic signed [sint_pkg::DIFF_W-1:0] diff;
    logic [sint_pkg::POS_W-1:0]         eff;
    logic [sint_pkg::DIVISOR_W:0]       rem_shift;
    logic [sint_pkg::DIVISOR_W:0]       rem_new;
    logic                               rem_ge;
    logic [sint_pkg::RESULT_W-1:0]      q_low;
    logic [QHI_W-1:0]                   q_high;
    logic                               sat_ovf;
    logic [sint_pkg::RESULT_W-1:0]      sat_value;
    logic                               out_free;
    logic                               load_out;

    assign o_pop    = (r_state == ST_ACCUM) && i_not_empty;
    assign contrib  = $signed(i_entry.sample) * $signed({1'b0, i_entry.weight});
    assign sum_next = r_sum + sint_pkg::SUM_W'(contrib);
    assign diff     = sint_pkg::DIFF_W'($signed(i_cfg.upper_bound))
                    - sint_pkg::DIFF_W'($signed(i_cfg.lower_bound));
    assign eff      = sint_pkg::eff_n(i_cfg.interval_count);

    // One restoring division step per cycle; the quotient shifts in where the dividend leaves.
    assign rem_shift = {r_rem, r_quot[sint_pkg::PROD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_div};
    assign rem_new   = rem_ge ? rem_shift - {1'b0, r_div} : rem_shift;

    assign q_low  = r_quot[sint_pkg::RESULT_W-1:0];
    assign q_high = r_quot[sint_pkg::PROD_W-1:sint_pkg::RESULT_W];

    always_comb begin
        if (!r_neg) begin
            sat_ovf   = (q_high != '0) || q_low[sint_pkg::RESULT_W-1];
            sat_value = sat_ovf ? sint_pkg::RESULT_MAX : q_low;
        end else begin
            sat_ovf   = (q_high != '0)
                      || (q_low[sint_pkg::RESULT_W-1] && q_low[sint_pkg::RESULT_W-2:0] != '0);
            sat_value = sat_ovf ? sint_pkg::RESULT_MIN : ('0 - q_low);
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;
    assign load_out = (r_state == ST_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCUM: begin
                if (o_pop && i_entry.last) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN:   n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_SUM;
            ST_SUM:    n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_ACCUM;
                end
            end
            default:   n_state = ST_ACCUM;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACCUM;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (o_pop) begin
                r_sum <= i_entry.last ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_total <= sum_next;
        end
        if (r_state == ST_SIGN) begin
            r_neg  <= diff[sint_pkg::DIFF_W-1] ^ r_total[sint_pkg::SUM_W-1];
            r_dmag <= diff[sint_pkg::DIFF_W-1] ? sint_pkg::DIFF_W'(-diff)
                                               : sint_pkg::DIFF_W'(diff);
            r_smag <= r_total[sint_pkg::SUM_W-1] ? sint_pkg::SUM_W'(-r_total)
                                                 : sint_pkg::SUM_W'(r_total);
            r_div  <= sint_pkg::DIVISOR_W'({eff, 2'b00}) + sint_pkg::DIVISOR_W'({eff, 1'b0});
        end
        if (r_state == ST_MUL_LO) begin
            r_plo <= (sint_pkg::DIFF_W+LO_W)'(r_dmag) * (sint_pkg::DIFF_W+LO_W)'(r_smag[LO_W-1:0]);
        end
        if (r_state == ST_MUL_HI) begin
            r_phi <= (sint_pkg::DIFF_W+HI_W)'(r_dmag)
                   * (sint_pkg::DIFF_W+HI_W)'(r_smag[sint_pkg::SUM_W-1:LO_W]);
        end
        if (r_state == ST_SUM) begin
            r_quot <= sint_pkg::PROD_W'(r_plo) + (sint_pkg::PROD_W'(r_phi) << LO_W);
            r_rem  <= '0;
            r_cnt  <= CNT_W'(sint_pkg::PROD_W - 1);
        end
        if (r_state == ST_DIV) begin
            r_quot <= {r_quot[sint_pkg::PROD_W-2:0], rem_ge};
            r_rem  <= rem_new[sint_pkg::DIVISOR_W-1:0];
            r_cnt  <= r_cnt - CNT_W'(1);
        end
        if (load_out) begin
            r_out_value <= sat_value;
            r_out_ovf   <= sat_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_integral  = r_out_value;
    assign o_overflow  = r_out_ovf;

endmodule

>>> rtl/core/sint_checker.sv
// Port-level checker for the sampled integral core, bound to the top level.
`include "sampled_integral_1d_core_macros.svh"

module sint_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sint_pkg::RESULT_W-1:0] o_integral_value,
    input logic                          o_overflow_flag
);

    // A stalled result beat stays put until it is taken.
    `SINT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_integral_value) && $stable(o_overflow_flag))

    // A saturated result is always one of the two extreme values.
    `SINT_ASSERT_NOW(a_ovf_extreme, o_out_valid && o_overflow_flag, (o_integral_value == sint_pkg::RESULT_MAX) || (o_integral_value == sint_pkg::RESULT_MIN))

    // Leaving reset, no result is pending.
    `SINT_ASSERT_NOW(a_reset_empty, $rose(i_rst_n), !o_out_valid)

endmodule

bind sampled_integral_1d_core sint_checker u_sint_checker (.*);

>>> verif/integral_checker.sv
// Checker that predicts every integral beat of the sampled integral core and compares it.
module integral_checker
    import sint_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [SAMPLE_W-1:0]    i_sample_value,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [RESULT_W-1:0]    i_integral_value,
    input  logic                   i_overflow_flag,
    output int                     o_pending,
    output int                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [127:0] QUOT_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] QUOT_MIN = -128'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic                saturated;
    } integral_beat_t;

    integral_beat_t integral_due[$];

    logic                      rule_sel;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [BOUND_W-1:0] lower_reg;
    logic signed [BOUND_W-1:0] upper_reg;
    int unsigned               run_pos;
    logic signed [63:0]        run_sum;
    int                        fails = 0;

    function automatic int unsigned used_count(input logic [COUNT_W-1:0] count);
        if (count == '0) begin
            return 1;
        end
        if (int'(count) > MAX_INTERVALS) begin
            return MAX_INTERVALS;
        end
        return int'(count);
    endfunction

    // Weight of grid point p out of n intervals under the selected rule.
    function automatic logic [WEIGHT_W-1:0] rule_weight(input int unsigned p,
                                                        input int unsigned n,
                                                        input logic rule);
        int unsigned even_span;
        logic [WEIGHT_W-1:0] w;
        even_span = n - (n % 2);
        w = '0;
        if (rule == MODE_TRAPEZOID) begin
            return (p == 0 || p == n) ? W_TRAP_END : W_TRAP_INNER;
        end
        if (even_span > 0 && p <= even_span) begin
            if (p == 0 || p == even_span) begin
                w = W_SIMP_END;
            end else if (p % 2 == 1) begin
                w = W_SIMP_ODD;
            end else begin
                w = W_SIMP_EVEN;
            end
        end
        if (n % 2 == 1 && (p == n - 1 || p == n)) begin
            w = w + W_TAIL;
        end
        return w;
    endfunction

    // (upper - lower) * sum / (6n), truncated toward zero and saturated to 64 bits.
    function automatic integral_beat_t scale_integral(input logic signed [63:0] sum,
                                                      input logic signed [BOUND_W-1:0] lo,
                                                      input logic signed [BOUND_W-1:0] hi,
                                                      input int unsigned n);
        logic signed [127:0] span_w;
        logic signed [127:0] prod;
        logic signed [127:0] divisor;
        logic signed [127:0] quot;
        integral_beat_t      beat;
        span_w  = hi - lo;
        prod    = span_w * sum;
        divisor = 6 * n;
        quot    = prod / divisor;
        if (quot > QUOT_MAX) begin
            beat = '{RESULT_MAX, 1'b1};
        end else if (quot < QUOT_MIN) begin
            beat = '{RESULT_MIN, 1'b1};
        end else begin
            beat = '{quot[RESULT_W-1:0], 1'b0};
        end
        return beat;
    endfunction

    always @(posedge i_clk) begin : watch
        integral_beat_t     want;
        int unsigned        n;
        int unsigned        p;
        logic               closing;
        logic signed [63:0] sample_sx;
        if (!i_rst_n) begin
            rule_sel  = MODE_TRAPEZOID;
            count_reg = COUNT_W'(1);
            lower_reg = '0;
            upper_reg = '0;
            run_pos   = 0;
            run_sum   = '0;
            integral_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (integral_due.size() == 0) begin
                    fails++;
                    $display("%0t: integral beat with none expected: value %h overflow %b",
                             $realtime, i_integral_value, i_overflow_flag);
                end else begin
                    want = integral_due.pop_front();
                    if (i_integral_value !== want.value) begin
                        fails++;
                        $display("%0t: integral_value expected %h actual %h",
                                 $realtime, want.value, i_integral_value);
                    end
                    if (i_overflow_flag !== want.saturated) begin
                        fails++;
                        $display("%0t: overflow_flag expected %b actual %b",
                                 $realtime, want.saturated, i_overflow_flag);
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RULE_MODE:      rule_sel  = i_cfg_data[0];
                    CFG_INTERVAL_COUNT: count_reg = i_cfg_data[COUNT_W-1:0];
                    CFG_LOWER_BOUND:    lower_reg = i_cfg_data;
                    CFG_UPPER_BOUND:    upper_reg = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                n         = used_count(count_reg);
                closing   = (run_pos >= n);
                p         = closing ? n : run_pos;
                sample_sx = $signed(i_sample_value);
                run_sum   = run_sum + sample_sx * $signed({1'b0, rule_weight(p, n, rule_sel)});
                if (closing) begin
                    integral_due.push_back(scale_integral(run_sum, lower_reg, upper_reg, n));
                    run_pos = 0;
                    run_sum = '0;
                end else begin
                    run_pos++;
                end
            end
        end
        o_pending    <= integral_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/testbench.sv
// Top of the sampled integral core testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sint_pkg::*;

    // The scaling unit still works after the closing sample of a run.
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 1325;

    typedef struct {
        logic [CFG_INDEX_W-1:0] addr;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    // How the result side paces itself during one stretch.
    typedef enum {SINK_OPEN, SINK_COIN, SINK_RARE, SINK_HOLD} sink_mode_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [SAMPLE_W-1:0]    i_sample_value;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [RESULT_W-1:0]    o_integral_value;
    logic                   o_overflow_flag;

    int pending;
    int fail_count;

    // Register writes queued for the next idle window, and the count they leave behind.
    reg_write_t         reg_plan[$];
    logic [COUNT_W-1:0] count_now = COUNT_W'(1);
    // Beats left in the current sender burst.
    int                 burst_left = 0;

    sampled_integral_1d_core DUT (.*);

    integral_checker scoreboard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_sample_value   (i_sample_value),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_integral_value (o_integral_value),
        .i_overflow_flag  (o_overflow_flag),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case a beat never arrives or a handshake hangs.
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    // The result side stalls in stretches: open, coin flips, rare stalls, or a solid hold.
    // Stretches are long enough that gaps land on every phase of a run.
    initial begin : result_sink
        sink_mode_t mode;
        int         len;
        i_out_stall <= 1'b0;
        forever begin
            mode = sink_mode_t'($urandom_range(0, 3));
            len  = (mode == SINK_HOLD) ? $urandom_range(1, 20) : $urandom_range(10, 200);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    SINK_OPEN: i_out_stall <= 1'b0;
                    SINK_COIN: i_out_stall <= 1'($urandom_range(0, 1));
                    SINK_RARE: i_out_stall <= ($urandom_range(0, 7) == 0);
                    default:   i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    function automatic void plan_reg(input logic [CFG_INDEX_W-1:0] addr,
                                     input logic [CFG_DATA_W-1:0] data);
        reg_plan.push_back('{addr, data});
        if (addr == CFG_INTERVAL_COUNT) begin
            count_now = data[COUNT_W-1:0];
        end
    endfunction

    // Sample mix: full-range noise, small Q16.16 values around zero, and both extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return 32'($urandom_range(0, 32'h000C_0000)) - 32'h0006_0000;
            7:          return 32'h7FFF_FFFF;
            8:          return 32'h8000_0000;
            default:    return 32'($urandom_range(0, 3)) - 32'd2;
        endcase
    endfunction

    // Bounds are mostly a few units apart, sometimes anywhere, sometimes at the edges.
    function automatic logic [BOUND_W-1:0] pick_bound();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            5, 6, 7:       return $urandom();
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0001_0000;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    // Mostly short runs; zero, medium and any 13-bit count (clamped above 4096) now and then.
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            14, 15:  return '0;
            16, 17:  return COUNT_W'($urandom_range(13, 64));
            18:      return COUNT_W'($urandom_range(0, 8191));
            default: return COUNT_W'($urandom_range(1, 12));
        endcase
    endfunction

    // One sample beat. Bursts of random length are separated by random gaps; a gap of zero
    // leaves valid high so that bursts run back to back.
    task automatic put_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop the sample stream and wait for every outstanding beat, then give the core time to
    // drain samples that close no run.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only while the core is idle; valid stays up across a batch of writes.
    task automatic program_regs();
        reg_write_t w;
        wait_idle();
        while (reg_plan.size() > 0) begin
            w = reg_plan.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.addr;
            i_cfg_data  <= w.data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int                 random_sent;
        int                 span;
        int                 phase_len;
        logic [CFG_DATA_W-1:0] junk;

        random_sent = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_sample_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the core integrates one interval between equal bounds, so the first
        // beat is zero whatever the samples are.
        put_sample(32'h7FFF_FFFF);
        put_sample(32'h8000_0000);

        // A count of zero acts as one. The span is the widest possible, and writes to
        // unused register indexes must leave everything alone.
        plan_reg(CFG_INTERVAL_COUNT, 32'd0);
        plan_reg(CFG_LOWER_BOUND, 32'h8000_0000);
        plan_reg(CFG_UPPER_BOUND, 32'h7FFF_FFFF);
        plan_reg(CFG_INDEX_W'(4), 32'hFFFF_FFFF);
        plan_reg(CFG_INDEX_W'(255), 32'hFFFF_FFFF);
        program_regs();
        put_sample(32'h7FFF_FFFF);
        put_sample(32'h7FFF_FFFF);

        // Reversed bounds flip the sign. Simpson over three intervals adds the trapezoid
        // tail on the last interval.
        plan_reg(CFG_RULE_MODE, 32'(MODE_SIMPSON));
        plan_reg(CFG_INTERVAL_COUNT, 32'd3);
        plan_reg(CFG_LOWER_BOUND, 32'h7FFF_FFFF);
        plan_reg(CFG_UPPER_BOUND, 32'h8000_0000);
        program_regs();
        put_sample(32'h8000_0000);
        put_sample(32'h0001_0000);
        put_sample(32'hFFFF_0000);
        put_sample(32'h7FFF_FFFF);

        // Simpson over four intervals uses the plain 2,8,4,8,2 pattern.
        plan_reg(CFG_INTERVAL_COUNT, 32'd4);
        plan_reg(CFG_LOWER_BOUND, 32'h0000_0000);
        plan_reg(CFG_UPPER_BOUND, 32'h0004_0000);
        program_regs();
        put_sample(32'h0001_0000);
        put_sample(32'h0002_0000);
        put_sample(32'h0003_0000);
        put_sample(32'h0004_0000);
        put_sample(32'h0005_0000);

        // A trapezoid run over eight intervals is cut short by a count of one: the next
        // sample is past the count and closes the run, but the sum is only divided by six,
        // so the widest span overflows upward.
        plan_reg(CFG_RULE_MODE, 32'(MODE_TRAPEZOID));
        plan_reg(CFG_INTERVAL_COUNT, 32'd8);
        plan_reg(CFG_LOWER_BOUND, 32'h8000_0000);
        plan_reg(CFG_UPPER_BOUND, 32'h7FFF_FFFF);
        program_regs();
        repeat (5) put_sample(32'h7FFF_FFFF);
        plan_reg(CFG_INTERVAL_COUNT, 32'd1);
        program_regs();
        put_sample(32'h7FFF_FFFF);

        // The same with the span reversed saturates downward.
        plan_reg(CFG_INTERVAL_COUNT, 32'd8);
        plan_reg(CFG_LOWER_BOUND, 32'h7FFF_FFFF);
        plan_reg(CFG_UPPER_BOUND, 32'h8000_0000);
        program_regs();
        repeat (5) put_sample(32'h7FFF_FFFF);
        plan_reg(CFG_INTERVAL_COUNT, 32'd1);
        program_regs();
        put_sample(32'h7FFF_FFFF);

        // Random phases. Each one rewrites a random subset of the registers in an idle
        // window and then streams samples. A phase can end part way through a run, so the
        // next setting lands mid-run and may leave the position past the new count.
        while (random_sent < RANDOM_ITEMS) begin
            junk = ($urandom_range(0, 1) == 1) ? $urandom() : '0;
            if ($urandom_range(0, 2) == 0) begin
                plan_reg(CFG_RULE_MODE, {junk[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
            end
            if ($urandom_range(0, 1) == 0) begin
                plan_reg(CFG_INTERVAL_COUNT, {junk[CFG_DATA_W-1:COUNT_W], pick_count()});
            end
            if ($urandom_range(0, 2) == 0) begin
                plan_reg(CFG_LOWER_BOUND, pick_bound());
            end
            if ($urandom_range(0, 2) == 0) begin
                plan_reg(CFG_UPPER_BOUND, pick_bound());
            end
            if ($urandom_range(0, 7) == 0) begin
                plan_reg(CFG_INDEX_W'($urandom_range(4, 255)), $urandom());
            end
            program_regs();

            span = (count_now == '0) ? 1
                 : (int'(count_now) > MAX_INTERVALS) ? MAX_INTERVALS : int'(count_now);
            phase_len = $urandom_range(1, (span >= 16) ? 48 : 3 * (span + 1));
            repeat (phase_len) begin
                put_sample(pick_sample());
                random_sent++;
            end
        end

        // Every beat must have arrived and matched, with nothing stray in the settle window.
        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
